[design/lcdws_pkg.sv]
// ============================================================================
// lcdws_pkg
// Shared types, constants and helpers for the 4-bit LCD write sequencer.
// ============================================================================
package lcdws_pkg;

    localparam int CNT_W = 16;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int REG_COUNT = 8;
    localparam int ADDR_W    = $clog2(REG_COUNT) + 2;

    localparam logic [7:0] INIT_WORD    = 8'h33;
    localparam logic [7:0] HOME_WORD    = 8'h02;
    localparam logic [7:0] CLEAR_WORD   = 8'h01;
    localparam logic [7:0] CURSOR0_WORD = 8'h80;
    localparam logic [3:0] CLEAR_STEP   = 4'd7;
    localparam logic [3:0] LAST_STEP    = 4'd8;

    typedef enum logic [1:0] {
        FN_TICK = 2'd0,
        FN_CMD  = 2'd1,
        FN_DATA = 2'd2,
        FN_INIT = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PWRUP   = 3'd1,
        PH_HI      = 3'd2,
        PH_MID     = 3'd3,
        PH_LO      = 3'd4,
        PH_SETTLE  = 3'd5,
        PH_CLRWAIT = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        REG_PULSE    = 3'd0,
        REG_CMD_WAIT = 3'd1,
        REG_DAT_WAIT = 3'd2,
        REG_PWR_WAIT = 3'd3,
        REG_CLR_WAIT = 3'd4,
        REG_FUNC_SET = 3'd5,
        REG_DISP_CTL = 3'd6,
        REG_ENTRY    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] pulse_ticks;
        logic [15:0] command_wait_ticks;
        logic [15:0] data_wait_ticks;
        logic [15:0] powerup_wait_ticks;
        logic [15:0] clear_wait_ticks;
        logic [7:0]  function_set_word;
        logic [7:0]  display_control_word;
        logic [7:0]  entry_mode_word;
    } cfg_t;

    typedef struct packed {
        phase_t           phase;
        logic [CNT_W-1:0] wait_count;
        logic [7:0]       held_byte;
        logic             held_select;
        logic [3:0]       init_step;
        logic             in_init;
        logic             pin_rs;
        logic             pin_en;
        logic [3:0]       pin_data;
    } state_t;

    typedef struct packed {
        logic       pin_rs;
        logic       pin_en;
        logic [3:0] pin_data;
        logic       busy;
        logic       done;
        logic       rejected;
    } res_t;

    // Saturate a 16-bit register target to the counter range.
    function automatic logic [CNT_W-1:0] clamp_target(input logic [15:0] t);
        logic [31:0] t32;
        t32 = 32'(t);
        if (t32 > 32'(CNT_MAX))
            return CNT_MAX;
        return CNT_W'(t32);
    endfunction

    function automatic logic [7:0] init_word(input logic [3:0] step, input cfg_t cfg);
        case (step)
            4'd0, 4'd1, 4'd2: return INIT_WORD;
            4'd3:             return HOME_WORD;
            4'd4:             return cfg.function_set_word;
            4'd5:             return cfg.display_control_word;
            4'd6:             return cfg.entry_mode_word;
            4'd7:             return CLEAR_WORD;
            default:          return CURSOR0_WORD;
        endcase
    endfunction

    // Load a byte and raise enable with its high nibble.
    function automatic state_t start_send(input state_t s, input logic [7:0] b,
                                          input logic sel);
        state_t n;
        n             = s;
        n.held_byte   = b;
        n.held_select = sel;
        n.pin_rs      = sel;
        n.pin_en      = 1'b1;
        n.pin_data    = b[7:4];
        n.phase       = PH_HI;
        n.wait_count  = '0;
        return n;
    endfunction

endpackage

[design/lcd_4bit_write_sequencer.sv]
// ============================================================================
// lcd_4bit_write_sequencer
// Character LCD driver for a 4-bit bus: writes command and data bytes as
// two nibbles with timed enable pulses and runs the power-up init sequence.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer: func
//   selects tick, command write, data write or initialize; value is the
//   byte for writes. Ticks are the only items that advance time, so the
//   caller paces the display timing by how often it sends ticks.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   item: the pin levels after the item, busy, done and rejected.
//   A request that arrives while busy is dropped with rejected set.
//   The item is held in the input register and passes through the step
//   logic into the result register. Throughput is one item per cycle
//   while the receiver does not stall; the phase register and wait
//   counter are updated in the same cycle a result is produced.
//   While the receiver stalls, the result register holds and the input
//   register still takes one more item; in_stall rises only when both are
//   full. At reset the sequencer state is idle with its pins low and the
//   configuration registers at their default timings and words.
//   Configuration sits on an APB-style port, register i at byte 4*i.
// ============================================================================
module lcd_4bit_write_sequencer (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   func,
    input  logic [7:0]                   value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         pin_rs,
    output logic                         pin_rw,
    output logic                         pin_en,
    output logic [3:0]                   pin_data,
    output logic                         busy_res,
    output logic                         done_res,
    output logic                         rejected,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lcdws_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import lcdws_pkg::*;

    cfg_t       cfg;
    state_t     state_reg;
    state_t     state_next;
    res_t       res_next;
    res_t       res_reg;
    logic       res_valid_reg;
    logic       in_valid_reg;
    logic [1:0] func_reg;
    logic [7:0] value_reg;
    logic       advance;
    logic       take;

    lcdws_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Step logic works on the held item against the current state.
    lcdws_engine u_engine (
        .func    (func_reg),
        .value   (value_reg),
        .cfg     (cfg),
        .st      (state_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    // Advance the held item when the result register is free or draining.
    assign advance  = in_valid_reg && !(res_valid_reg && out_stall);
    assign in_stall = in_valid_reg && res_valid_reg && out_stall;
    assign take     = in_valid && !in_stall;

    // Input register: payload needs no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            func_reg  <= func;
            value_reg <= value;
        end
    end

    // Sequencer state: commit only when the item moves into the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_IDLE;
            state_reg.wait_count  <= '0;
            state_reg.held_byte   <= '0;
            state_reg.held_select <= 1'b0;
            state_reg.init_step   <= '0;
            state_reg.in_init     <= 1'b0;
            state_reg.pin_rs      <= 1'b0;
            state_reg.pin_en      <= 1'b0;
            state_reg.pin_data    <= '0;
        end
        else if (advance)
            state_reg <= state_next;
    end

    // Result register: hold while stalled, drop valid once transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (!out_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid = res_valid_reg;
    assign pin_rs    = res_reg.pin_rs;
    assign pin_rw    = 1'b0;
    assign pin_en    = res_reg.pin_en;
    assign pin_data  = res_reg.pin_data;
    assign busy_res  = res_reg.busy;
    assign done_res  = res_reg.done;
    assign rejected  = res_reg.rejected;

endmodule

[design/lcdws_regs.sv]
// ============================================================================
// lcdws_regs
// Configuration register file behind the APB-style port.
// ============================================================================
module lcdws_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lcdws_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output lcdws_pkg::cfg_t              cfg
);
    import lcdws_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr     = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_ticks          <= 16'd3;
            cfg_reg.command_wait_ticks   <= 16'd5000;
            cfg_reg.data_wait_ticks      <= 16'd0;
            cfg_reg.powerup_wait_ticks   <= 16'd45000;
            cfg_reg.clear_wait_ticks     <= 16'd3000;
            cfg_reg.function_set_word    <= 8'd40;
            cfg_reg.display_control_word <= 8'd12;
            cfg_reg.entry_mode_word      <= 8'd6;
        end
        else if (wr)
        begin
            case (idx)
                REG_PULSE:    cfg_reg.pulse_ticks          <= pwdata[15:0];
                REG_CMD_WAIT: cfg_reg.command_wait_ticks   <= pwdata[15:0];
                REG_DAT_WAIT: cfg_reg.data_wait_ticks      <= pwdata[15:0];
                REG_PWR_WAIT: cfg_reg.powerup_wait_ticks   <= pwdata[15:0];
                REG_CLR_WAIT: cfg_reg.clear_wait_ticks     <= pwdata[15:0];
                REG_FUNC_SET: cfg_reg.function_set_word    <= pwdata[7:0];
                REG_DISP_CTL: cfg_reg.display_control_word <= pwdata[7:0];
                REG_ENTRY:    cfg_reg.entry_mode_word      <= pwdata[7:0];
                default:      cfg_reg.pulse_ticks          <= cfg_reg.pulse_ticks;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_PULSE:    prdata = 32'(cfg_reg.pulse_ticks);
            REG_CMD_WAIT: prdata = 32'(cfg_reg.command_wait_ticks);
            REG_DAT_WAIT: prdata = 32'(cfg_reg.data_wait_ticks);
            REG_PWR_WAIT: prdata = 32'(cfg_reg.powerup_wait_ticks);
            REG_CLR_WAIT: prdata = 32'(cfg_reg.clear_wait_ticks);
            REG_FUNC_SET: prdata = 32'(cfg_reg.function_set_word);
            REG_DISP_CTL: prdata = 32'(cfg_reg.display_control_word);
            REG_ENTRY:    prdata = 32'(cfg_reg.entry_mode_word);
            default:      prdata = '0;
        endcase
    end

endmodule

[design/lcdws_engine.sv]
// ============================================================================
// lcdws_engine
// Next-state and result logic for one tick or request.
// ============================================================================
module lcdws_engine (
    input  logic [1:0]          func,
    input  logic [7:0]          value,
    input  lcdws_pkg::cfg_t     cfg,
    input  lcdws_pkg::state_t   st,
    output lcdws_pkg::state_t   st_next,
    output lcdws_pkg::res_t     res
);
    import lcdws_pkg::*;

    func_t            fn;
    logic [15:0]      target;
    logic [CNT_W-1:0] wc_inc;
    logic             met;
    logic             done;
    logic             rej;
    state_t           n;

    assign fn     = func_t'(func);
    assign wc_inc = (st.wait_count != CNT_MAX) ? st.wait_count + 1'b1 : st.wait_count;
    assign met    = wc_inc >= clamp_target(target);

    always_comb
    begin
        case (st.phase)
            PH_PWRUP:        target = cfg.powerup_wait_ticks;
            PH_HI, PH_LO:    target = cfg.pulse_ticks;
            PH_SETTLE:       target = st.held_select ? cfg.data_wait_ticks
                                                     : cfg.command_wait_ticks;
            PH_CLRWAIT:      target = cfg.clear_wait_ticks;
            default:         target = '0;
        endcase
    end

    always_comb
    begin
        n    = st;
        done = 1'b0;
        rej  = 1'b0;
        if (fn != FN_TICK)
        begin
            if (st.phase != PH_IDLE)
                rej = 1'b1;
            else if (fn == FN_INIT)
            begin
                n.pin_rs     = 1'b0;
                n.pin_en     = 1'b0;
                n.pin_data   = '0;
                n.in_init    = 1'b1;
                n.init_step  = '0;
                n.phase      = PH_PWRUP;
                n.wait_count = '0;
            end
            else
                n = start_send(st, value, fn == FN_DATA);
        end
        else
        begin
            case (st.phase)
                PH_PWRUP:
                begin
                    n.wait_count = wc_inc;
                    if (met)
                        n = start_send(st, init_word(4'd0, cfg), 1'b0);
                end
                PH_HI:
                begin
                    n.wait_count = wc_inc;
                    if (met)
                    begin
                        n.pin_en = 1'b0;
                        n.phase  = PH_MID;
                    end
                end
                PH_MID:
                begin
                    n.pin_en     = 1'b1;
                    n.pin_data   = st.held_byte[3:0];
                    n.phase      = PH_LO;
                    n.wait_count = '0;
                end
                PH_LO:
                begin
                    n.wait_count = wc_inc;
                    if (met)
                    begin
                        n.pin_en     = 1'b0;
                        n.phase      = PH_SETTLE;
                        n.wait_count = '0;
                    end
                end
                PH_SETTLE:
                begin
                    n.wait_count = wc_inc;
                    if (met)
                    begin
                        if (!st.in_init)
                        begin
                            n.phase = PH_IDLE;
                            done    = 1'b1;
                        end
                        else if (st.init_step >= LAST_STEP)
                        begin
                            n.in_init   = 1'b0;
                            n.init_step = '0;
                            n.phase     = PH_IDLE;
                            done        = 1'b1;
                        end
                        else if (st.init_step == CLEAR_STEP)
                        begin
                            n.init_step  = st.init_step + 1'b1;
                            n.phase      = PH_CLRWAIT;
                            n.wait_count = '0;
                        end
                        else
                        begin
                            n = start_send(st, init_word(st.init_step + 1'b1, cfg), 1'b0);
                            n.init_step = st.init_step + 1'b1;
                        end
                    end
                end
                PH_CLRWAIT:
                begin
                    n.wait_count = wc_inc;
                    if (met)
                        n = start_send(st, init_word(st.init_step, cfg), 1'b0);
                end
                default:
                    n.phase = PH_IDLE;
            endcase
        end
    end

    assign st_next      = n;
    assign res.pin_rs   = n.pin_rs;
    assign res.pin_en   = n.pin_en;
    assign res.pin_data = n.pin_data;
    assign res.busy     = n.phase != PH_IDLE;
    assign res.done     = done;
    assign res.rejected = rej;

endmodule

[design/lcdws_checker.sv]
// ============================================================================
// lcdws_checker
// Port-level checks on the sequencer result stream.
// ============================================================================
module lcdws_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         pin_rs,
    input logic                         pin_rw,
    input logic                         pin_en,
    input logic [3:0]                   pin_data,
    input logic                         busy_res,
    input logic                         done_res,
    input logic                         rejected
);
    import lcdws_pkg::*;

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid &&
            $stable({pin_rs, pin_en, pin_data, busy_res, done_res, rejected}))
        else $error("result changed while stalled");

    // Only a busy sequencer rejects.
    a_rej_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rejected |-> busy_res && !done_res)
        else $error("reject without busy");

    // Finishing leaves the sequencer idle with enable low.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res && !pin_en)
        else $error("done while busy or enable high");

    // Enable high only in the middle of a transfer.
    a_en_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pin_en |-> busy_res && !pin_rw)
        else $error("enable high while idle");

endmodule

bind lcd_4bit_write_sequencer lcdws_checker u_lcdws_checker (.*);
